// ----- rtl/core/mvm_pkg.sv -----
// Shared types and constants for the matrix-vector multiply core.
`default_nettype none

package mvm_pkg;

    localparam int IDX_W  = 10;
    localparam int SIZE_W = 11;
    localparam int VAL_W  = 32;
    localparam int SUM_W  = 64;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // Transaction kinds.
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_MAC  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // Result status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic [1:0]              kind;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [VAL_W-1:0] value;
    } mvm_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]        row_out;
        logic signed [SUM_W-1:0] sum;
        logic                    saturated;
        logic                    status;
    } mvm_out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_READ,
        ST_RESP
    } mvm_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/mvm_ram.sv -----
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none

module mvm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mvm_mac.sv -----
// Multiply stage and saturating accumulate stage of the row update.
`default_nettype none

module mvm_mac #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          prod_load,
    input  wire logic signed [VALUE_BITS-1:0]  elem,
    input  wire logic signed [VALUE_BITS-1:0]  vec,
    input  wire logic signed [mvm_pkg::SUM_W-1:0] acc_in,
    input  wire logic                          sat_in,
    output logic signed [mvm_pkg::SUM_W-1:0]   acc_out,
    output logic                               sat_out
);
    import mvm_pkg::*;

    localparam int PW = 2 * VALUE_BITS;

    logic signed [PW-1:0]    prod_reg;
    logic signed [PW-1:0]    prod_next;
    logic signed [SUM_W-1:0] prod_ext;
    logic signed [SUM_W-1:0] prod_sh;
    logic signed [SUM_W-1:0] sum_raw;
    logic                    ovf;

    assign prod_next = elem * vec;

    always_ff @(posedge clk)
    begin
        if (prod_load)
        begin
            prod_reg <= prod_next;
        end
    end

    // The arithmetic shift floors the Q32.32 product down to Q48.16.
    assign prod_ext = SUM_W'(prod_reg);
    assign prod_sh  = prod_ext >>> 16;
    assign sum_raw  = acc_in + prod_sh;
    assign ovf      = (acc_in[SUM_W-1] == prod_sh[SUM_W-1]) &&
                      (sum_raw[SUM_W-1] != acc_in[SUM_W-1]);

    always_comb
    begin
        if (ovf)
        begin
            acc_out = acc_in[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            acc_out = sum_raw;
        end
    end

    assign sat_out = sat_in | ovf;

endmodule

`default_nettype wire

// ----- rtl/core/matrix_vector_multiply_core.sv -----
// Top level of the memory-based dense matrix-vector multiply core.
//
// Usage: the input channel (in_valid, in_ready, in_data) carries one
// transaction per item: a vector load, a matrix element multiply-accumulate
// or a row read-and-clear. Results leave on the output channel (out_valid,
// out_ready, out_data); a load or multiply that succeeds yields no result,
// while an index at or above the configured size yields one error result.
// The size register is written through cfg_we and cfg_wdata while idle;
// the user must keep to this, as the core does not enforce it. It takes one
// transaction at a time, set by the accumulator read-modify-write: a load
// ends on acceptance, a multiply-accumulate reads, multiplies, then adds
// and writes back, a read-and-clear passes the read and response states,
// and an error the response state. Reset: the accumulator RAM is swept to
// zero, one row per cycle; in_ready stays low until the sweep ends. The
// vector RAM is not cleared. When the receiver stalls, a finished result
// sits in the output register while the core still accepts the next
// transaction; it only waits once a second result is ready to leave.
`default_nettype none

module matrix_vector_multiply_core #(
    parameter int MAX_DIM    = 1024,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire mvm_pkg::mvm_in_t            in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output mvm_pkg::mvm_out_t                out_data,
    input  wire logic                        cfg_we,
    input  wire logic [mvm_pkg::SIZE_W-1:0]  cfg_wdata
);
    import mvm_pkg::*;

    localparam int AW    = $clog2(MAX_DIM);
    localparam int ACC_W = SUM_W + 1;
    // Compare width wide enough for the largest supported dimension.
    localparam int CW    = 18;
    localparam logic [CW-1:0] MAX_DIM_C = CW'(MAX_DIM);
    localparam logic [AW-1:0] LAST_ROW  = AW'(MAX_DIM - 1);

    mvm_state_t state_reg;
    mvm_state_t state_next;

    logic [SIZE_W-1:0]     size_reg;
    logic [AW-1:0]         clr_cnt_reg;
    logic [IDX_W-1:0]      row_reg;
    logic [VALUE_BITS-1:0] value_reg;
    mvm_out_t              resp_reg;
    mvm_out_t              out_data_reg;
    logic                  out_valid_reg;

    logic [CW-1:0]         size_ext;
    logic [CW-1:0]         eff_size;
    logic                  row_ok;
    logic                  col_ok;
    logic                  accept;
    logic                  in_err;
    logic                  out_free;

    logic                  vec_we;
    logic [VALUE_BITS-1:0] vec_rdata;
    logic                  prod_load;
    logic                  acc_we;
    logic [AW-1:0]         acc_waddr;
    logic [ACC_W-1:0]      acc_wdata;
    logic [ACC_W-1:0]      acc_rdata;
    logic signed [SUM_W-1:0] mac_acc;
    logic                  mac_sat;
    logic                  resp_err_load;
    logic                  resp_read_load;
    logic                  out_load;

    // Effective size is the register clamped to the physical depth.
    assign size_ext = CW'(size_reg);
    assign eff_size = (size_ext > MAX_DIM_C) ? MAX_DIM_C : size_ext;
    assign row_ok   = CW'(in_data.row_index) < eff_size;
    assign col_ok   = CW'(in_data.col_index) < eff_size;
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (in_data.kind)
            KIND_LOAD: in_err = !col_ok;
            KIND_MAC:  in_err = !(row_ok && col_ok);
            KIND_READ: in_err = !row_ok;
            default:   in_err = 1'b0;
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_ROW)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_err)
                    begin
                        state_next = ST_RESP;
                    end
                    else if (in_data.kind == KIND_MAC)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (in_data.kind == KIND_READ)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = ST_IDLE;
            ST_READ: state_next = ST_RESP;
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output and datapath control logic.
    always_comb
    begin
        in_ready       = 1'b0;
        vec_we         = 1'b0;
        prod_load      = 1'b0;
        acc_we         = 1'b0;
        acc_waddr      = AW'(row_reg);
        acc_wdata      = '0;
        resp_err_load  = 1'b0;
        resp_read_load = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                acc_we    = 1'b1;
                acc_waddr = clr_cnt_reg;
            end
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                vec_we        = in_valid && (in_data.kind == KIND_LOAD) && col_ok;
                resp_err_load = in_valid && in_err;
            end
            ST_MUL:
            begin
                prod_load = 1'b1;
            end
            ST_ACC:
            begin
                acc_we    = 1'b1;
                acc_wdata = {mac_sat, mac_acc};
            end
            ST_READ:
            begin
                // Read-and-clear: the row returns to zero as it is reported.
                acc_we         = 1'b1;
                resp_read_load = 1'b1;
            end
            ST_RESP:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            size_reg      <= SIZE_RESET;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg   <= in_data.row_index;
            value_reg <= in_data.value[VALUE_BITS-1:0];
        end
        if (resp_err_load)
        begin
            resp_reg.row_out   <= in_data.row_index;
            resp_reg.sum       <= '0;
            resp_reg.saturated <= 1'b0;
            resp_reg.status    <= STATUS_RANGE;
        end
        else if (resp_read_load)
        begin
            resp_reg.row_out   <= row_reg;
            resp_reg.sum       <= acc_rdata[SUM_W-1:0];
            resp_reg.saturated <= acc_rdata[SUM_W];
            resp_reg.status    <= STATUS_OK;
        end
        if (out_load)
        begin
            out_data_reg <= resp_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Vector entries, written by load transactions.
    mvm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_DIM)
    ) u_vec_ram (
        .clk   (clk),
        .we    (vec_we),
        .waddr (AW'(in_data.col_index)),
        .wdata (in_data.value[VALUE_BITS-1:0]),
        .re    (accept),
        .raddr (AW'(in_data.col_index)),
        .rdata (vec_rdata)
    );

    // Row accumulators with the saturation mark in the top bit.
    mvm_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_DIM)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (accept),
        .raddr (AW'(in_data.row_index)),
        .rdata (acc_rdata)
    );

    mvm_mac #(
        .VALUE_BITS (VALUE_BITS)
    ) u_mac (
        .clk       (clk),
        .prod_load (prod_load),
        .elem      (value_reg),
        .vec       (vec_rdata),
        .acc_in    (acc_rdata[SUM_W-1:0]),
        .sat_in    (acc_rdata[SUM_W]),
        .acc_out   (mac_acc),
        .sat_out   (mac_sat)
    );

    // The accumulator RAM is never written in a cycle that starts a new read.
    a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(acc_we && accept))
        else $error("accumulator write overlaps a new transaction");

    // A result only appears after the response state handed it over.
    a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("output valid rose outside the response state");

    // A valid row read clears that row in the following cycle.
    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.kind == KIND_READ) && row_ok)
            |=> (acc_we && (acc_wdata == '0) && (acc_waddr == AW'(row_reg))))
        else $error("row read did not clear the accumulator");

    // A multiply-accumulate writes back in the accumulate state, after the multiply state.
    a_mac_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.kind == KIND_MAC) && row_ok && col_ok)
            |=> ##1 (acc_we && (state_reg == ST_ACC)))
        else $error("multiply-accumulate write-back missing");

endmodule

`default_nettype wire

// ----- sim/matrix_vector_multiply_core_tb.sv -----
// Self-checking testbench for the matrix-vector multiply core.
`timescale 1ns / 1ps

module matrix_vector_multiply_core_tb;
    import mvm_pkg::*;

    localparam int MAX_DIM      = 1024;
    localparam int FRAC_BITS    = 16;
    localparam int RESET_CYCLES = 10;
    localparam int IDLE_PERCENT = 21;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 20;
    localparam int STALL_LIMIT  = 6000;
    localparam int PHASE_ITEMS  = 180;
    localparam int MAX_REPORTS  = 10;

    // The fourth kind code is not used by the core and must be ignored.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Where the expected result of a stimulus row comes from.
    typedef enum logic [1:0] {
        FROM_PREDICTOR,
        TABLE_RESULT,
        TABLE_SILENT
    } exp_src_t;

    typedef struct {
        bit                is_cfg;
        logic [SIZE_W-1:0] cfg_value;
        exp_src_t          src;
        mvm_in_t           item;
        mvm_out_t          result;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    mvm_in_t           in_data;
    logic              out_valid;
    logic              out_ready;
    mvm_out_t          out_data;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;

    // Predictor state: the vector x, which entries of it have been loaded,
    // the row accumulators with their clamp marks, and the size register.
    logic signed [VAL_W-1:0] x_entry     [MAX_DIM];
    bit                      x_loaded    [MAX_DIM];
    logic signed [SUM_W-1:0] row_sum     [MAX_DIM];
    bit                      row_clamped [MAX_DIM];
    int                      active_size;

    // Results the core still owes, oldest first.
    mvm_out_t pending_results [$];
    plan_row_t plan [$];

    // Size settings of the random phases, the extremes among them.
    int phase_size [9] = '{1024, 16, 1, 2047, 5, 0, 1025, 64, 1024};

    bit steady        = 1'b0;
    int hold_requests = 0;
    int holds_done    = 0;
    int fail_count    = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int size_writes   = 0;
    int quiet_cycles  = 0;

    matrix_vector_multiply_core #(
        .MAX_DIM    (MAX_DIM),
        .VALUE_BITS (VAL_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sizes above the array depth behave as the full depth.
    function automatic int effective_size();
        return (active_size > MAX_DIM) ? MAX_DIM : active_size;
    endfunction

    // Advances the predictor by one transaction and reports whether the core
    // owes a result for it. The product of two Q16.16 values is floored to
    // Q48.16 by an arithmetic shift, then added to the row with clamping.
    function automatic bit gemv_step(input mvm_in_t t, output mvm_out_t r);
        int           n;
        longint       prod;
        logic [SUM_W:0] wide;
        n = effective_size();
        r = '0;
        r.row_out = t.row_index;
        r.status  = STATUS_OK;
        case (t.kind)
            KIND_LOAD:
            begin
                if (t.col_index >= n)
                begin
                    r.status = STATUS_RANGE;
                    return 1'b1;
                end
                x_entry[t.col_index]  = t.value;
                x_loaded[t.col_index] = 1'b1;
                return 1'b0;
            end
            KIND_MAC:
            begin
                if (t.row_index >= n || t.col_index >= n)
                begin
                    r.status = STATUS_RANGE;
                    return 1'b1;
                end
                prod = longint'($signed(t.value)) * longint'(x_entry[t.col_index]);
                prod = prod >>> FRAC_BITS;
                wide = {row_sum[t.row_index][SUM_W-1], row_sum[t.row_index]}
                     + {prod[SUM_W-1], prod};
                // The two top bits of the widened sum differ only on overflow.
                if (wide[SUM_W] != wide[SUM_W-1])
                begin
                    row_sum[t.row_index]     = wide[SUM_W] ? SUM_MIN : SUM_MAX;
                    row_clamped[t.row_index] = 1'b1;
                end
                else
                begin
                    row_sum[t.row_index] = wide[SUM_W-1:0];
                end
                return 1'b0;
            end
            KIND_READ:
            begin
                if (t.row_index >= n)
                begin
                    r.status = STATUS_RANGE;
                    return 1'b1;
                end
                r.sum       = row_sum[t.row_index];
                r.saturated = row_clamped[t.row_index];
                row_sum[t.row_index]     = '0;
                row_clamped[t.row_index] = 1'b0;
                return 1'b1;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    function automatic mvm_in_t gemv_item(input logic [1:0] kind,
                                          input logic [IDX_W-1:0] row,
                                          input logic [IDX_W-1:0] col,
                                          input logic signed [VAL_W-1:0] value);
        mvm_in_t t;
        t.kind      = kind;
        t.row_index = row;
        t.col_index = col;
        t.value     = value;
        return t;
    endfunction

    function automatic mvm_out_t row_result(input logic [IDX_W-1:0] row,
                                            input logic signed [SUM_W-1:0] sum,
                                            input logic sat,
                                            input logic status);
        mvm_out_t r;
        r.row_out   = row;
        r.sum       = sum;
        r.saturated = sat;
        r.status    = status;
        return r;
    endfunction

    function automatic plan_row_t plan_op(input exp_src_t src, input mvm_in_t item,
                                          input mvm_out_t result);
        plan_row_t p;
        p.is_cfg    = 1'b0;
        p.cfg_value = '0;
        p.src       = src;
        p.item      = item;
        p.result    = result;
        return p;
    endfunction

    function automatic plan_row_t plan_size(input logic [SIZE_W-1:0] value);
        plan_row_t p;
        p.is_cfg    = 1'b1;
        p.cfg_value = value;
        p.src       = TABLE_SILENT;
        p.item      = '0;
        p.result    = '0;
        return p;
    endfunction

    // Most indices fall on a few low rows so that reads find real sums, the
    // rest spread over the whole configured range.
    function automatic logic [IDX_W-1:0] pick_index(input int n);
        if (n == 0)
            return IDX_W'($urandom_range(0, MAX_DIM - 1));
        if ($urandom_range(0, 9) < 6)
            return IDX_W'($urandom_range(0, ((n < 8) ? n : 8) - 1));
        return IDX_W'($urandom_range(0, n - 1));
    endfunction

    function automatic logic signed [VAL_W-1:0] random_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (roll < 45)
            return $signed($urandom) >>> $urandom_range(8, 24);
        return $urandom;
    endfunction

    // Builds one random transaction. Multiplies that would read a vector
    // entry never loaded are turned into a load of that entry instead.
    function automatic mvm_in_t random_item(input int n);
        mvm_in_t t;
        int      roll;
        int      pick;
        logic [IDX_W-1:0] bad;
        t.kind      = KIND_READ;
        t.row_index = IDX_W'($urandom);
        t.col_index = IDX_W'($urandom);
        t.value     = random_value();
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            t.kind = KIND_UNUSED;
        end
        else if (roll < 9 && n < MAX_DIM)
        begin
            bad  = IDX_W'($urandom_range(n, MAX_DIM - 1));
            pick = $urandom_range(0, 5);
            if (pick < 2)
            begin
                t.kind      = KIND_LOAD;
                t.col_index = bad;
            end
            else if (pick < 4)
            begin
                t.kind = KIND_MAC;
                if (pick == 2)
                    t.row_index = bad;
                else
                    t.col_index = bad;
            end
            else
            begin
                t.row_index = bad;
            end
        end
        else if (roll < 26)
        begin
            t.kind      = KIND_LOAD;
            t.col_index = pick_index(n);
        end
        else if (roll < 78)
        begin
            t.kind      = KIND_MAC;
            t.row_index = pick_index(n);
            t.col_index = pick_index(n);
            if (n > 0 && !x_loaded[t.col_index])
                t.kind = KIND_LOAD;
        end
        else
        begin
            t.row_index = pick_index(n);
        end
        return t;
    endfunction

    // Offers one transaction, holding valid and payload until the core takes
    // it. Called and returning at a falling edge; idle gaps come first.
    task automatic send_item(input mvm_in_t item, input exp_src_t src,
                             input mvm_out_t table_result);
        mvm_out_t predicted;
        bit       has_result;
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        has_result = gemv_step(item, predicted);
        items_sent++;
        if (src == TABLE_RESULT)
            pending_results.push_back(table_result);
        else if (src == FROM_PREDICTOR && has_result)
            pending_results.push_back(predicted);
        @(negedge clk);
    endtask

    // The size register is only written once the core has gone quiet: all
    // owed results are back and a load or multiply still in flight has had
    // time to retire.
    task automatic set_size(input logic [SIZE_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we      <= 1'b0;
        active_size = int'(value);
        size_writes++;
    endtask

    // Stimulus: directed table, then random phases at several sizes. A row
    // needs about 2**17 full-scale products to reach a 64-bit limit, which
    // lies far beyond the length of this run.
    initial
    begin
        int p;
        int k;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = SIZE_RESET;
        rst_n     = 1'b0;
        for (k = 0; k < MAX_DIM; k++)
        begin
            x_entry[k]     = '0;
            x_loaded[k]    = 1'b0;
            row_sum[k]     = '0;
            row_clamped[k] = 1'b0;
        end
        active_size = int'(SIZE_RESET);

        // Rows straight after reset read back as zero.
        plan.push_back(plan_op(TABLE_RESULT, gemv_item(KIND_READ, 0, 0, 0),
                               row_result(0, 0, 1'b0, STATUS_OK)));
        plan.push_back(plan_op(TABLE_RESULT, gemv_item(KIND_READ, 1023, 0, 0),
                               row_result(1023, 0, 1'b0, STATUS_OK)));
        // Vector loads at the value and index extremes, plus 1.0, -1.0 and
        // the smallest step.
        plan.push_back(plan_op(TABLE_SILENT, gemv_item(KIND_LOAD, 0, 0, 32'h7FFF_FFFF), '0));
        plan.push_back(plan_op(TABLE_SILENT,
                               gemv_item(KIND_LOAD, 1023, 1023, 32'h8000_0000), '0));
        plan.push_back(plan_op(TABLE_SILENT, gemv_item(KIND_LOAD, 0, 1, 32'h0001_0000), '0));
        plan.push_back(plan_op(TABLE_SILENT, gemv_item(KIND_LOAD, 0, 2, 32'hFFFF_0000), '0));
        plan.push_back(plan_op(TABLE_SILENT, gemv_item(KIND_LOAD, 0, 3, 32'h0000_0001), '0));
        // 3.0 * 1.0 + 1.5 * -1.0 leaves 1.5 in row 5, and the read clears it.
        plan.push_back(plan_op(TABLE_SILENT, gemv_item(KIND_MAC, 5, 1, 32'h0003_0000), '0));
        plan.push_back(plan_op(TABLE_SILENT, gemv_item(KIND_MAC, 5, 2, 32'h0001_8000), '0));
        plan.push_back(plan_op(TABLE_RESULT, gemv_item(KIND_READ, 5, 0, 0),
                               row_result(5, 64'sh1_8000, 1'b0, STATUS_OK)));
        plan.push_back(plan_op(TABLE_RESULT, gemv_item(KIND_READ, 5, 0, 0),
                               row_result(5, 0, 1'b0, STATUS_OK)));
        // Full-scale products of both signs, and flooring of a tiny negative one.
        plan.push_back(plan_op(FROM_PREDICTOR,
                               gemv_item(KIND_MAC, 1023, 0, 32'h7FFF_FFFF), '0));
        plan.push_back(plan_op(FROM_PREDICTOR,
                               gemv_item(KIND_MAC, 1023, 1023, 32'h8000_0000), '0));
        plan.push_back(plan_op(FROM_PREDICTOR, gemv_item(KIND_READ, 1023, 0, 0), '0));
        plan.push_back(plan_op(FROM_PREDICTOR,
                               gemv_item(KIND_MAC, 0, 1023, 32'h7FFF_FFFF), '0));
        plan.push_back(plan_op(FROM_PREDICTOR, gemv_item(KIND_MAC, 0, 3, 32'hFFFF_FFFF), '0));
        plan.push_back(plan_op(FROM_PREDICTOR, gemv_item(KIND_MAC, 0, 3, 32'h0000_0001), '0));
        plan.push_back(plan_op(FROM_PREDICTOR, gemv_item(KIND_READ, 0, 0, 0), '0));
        // The unused kind gives nothing back.
        plan.push_back(plan_op(TABLE_SILENT,
                               gemv_item(KIND_UNUSED, 1023, 1023, 32'hFFFF_FFFF), '0));
        // With four rows, every kind of transaction can miss the range.
        plan.push_back(plan_size(11'd4));
        plan.push_back(plan_op(TABLE_RESULT, gemv_item(KIND_LOAD, 9, 4, 32'h0001_0000),
                               row_result(9, 0, 1'b0, STATUS_RANGE)));
        plan.push_back(plan_op(TABLE_RESULT, gemv_item(KIND_MAC, 4, 0, 32'h0001_0000),
                               row_result(4, 0, 1'b0, STATUS_RANGE)));
        plan.push_back(plan_op(TABLE_RESULT, gemv_item(KIND_MAC, 0, 1023, 32'h0001_0000),
                               row_result(0, 0, 1'b0, STATUS_RANGE)));
        plan.push_back(plan_op(TABLE_RESULT, gemv_item(KIND_READ, 4, 0, 0),
                               row_result(4, 0, 1'b0, STATUS_RANGE)));
        // A size of zero rejects everything; one above the depth acts as full.
        plan.push_back(plan_size(11'd0));
        plan.push_back(plan_op(TABLE_RESULT, gemv_item(KIND_READ, 0, 0, 0),
                               row_result(0, 0, 1'b0, STATUS_RANGE)));
        plan.push_back(plan_size(11'd2047));
        plan.push_back(plan_op(FROM_PREDICTOR,
                               gemv_item(KIND_MAC, 1023, 1023, 32'h0001_0000), '0));
        plan.push_back(plan_op(FROM_PREDICTOR, gemv_item(KIND_READ, 1023, 0, 0), '0));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[k])
        begin
            if (plan[k].is_cfg)
                set_size(plan[k].cfg_value);
            else
                send_item(plan[k].item, plan[k].src, plan[k].result);
        end

        // Random phases. One phase runs with no idling on either side; two of
        // them ask the receiver for a long hold-off while items keep coming.
        for (p = 0; p < $size(phase_size); p++)
        begin
            set_size(SIZE_W'(phase_size[p]));
            steady = (p == 3);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if ((p == 0 || p == 4) && k == 40)
                    hold_requests++;
                send_item(random_item(effective_size()), FROM_PREDICTOR, '0);
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d transactions and %0d checked results over %0d size writes,",
                 items_sent, results_seen, size_writes);
        $display("with range errors, ignored kinds, full-scale products and long stalls.");
        if (fail_count == 0)
            $display("PASS matrix_vector_multiply_core");
        else
            $display("FAIL matrix_vector_multiply_core");
        $finish;
    end

    // Receiver. It idles at random, except during the steady phases, and
    // serves each hold-off request with a long stretch of ready held low.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests > holds_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds_done++;
            end
            else
            begin
                out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Result checker: each accepted result must match the oldest owed one.
    initial
    begin
        mvm_out_t got;
        mvm_out_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result row %0d sum %0d sat %0b status %0b",
                                 $time, got.row_out, got.sum, got.saturated, got.status);
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_seen++;
                    if (got.row_out !== want.row_out || got.sum !== want.sum ||
                        got.saturated !== want.saturated || got.status !== want.status)
                    begin
                        fail_count++;
                        // Fields are row, sum, saturation mark and status.
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: mismatch exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                     $time, want.row_out, want.sum, want.saturated,
                                     want.status, got.row_out, got.sum, got.saturated,
                                     got.status);
                    end
                end
            end
        end
    end

    // Watchdog: too many cycles in a row without any transaction on either
    // channel means the core has hung. The limit covers the clearing sweep
    // after reset and the long receiver hold-off several times over.
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transaction for %0d cycles, %0d results still owed",
                 $time, STALL_LIMIT, pending_results.size());
        $display("FAIL matrix_vector_multiply_core");
        $finish;
    end

endmodule
